FILE: rtl/arc_pkg.sv
// Shared types, character constants and digit helpers for the ASCII radix converter.
// No dependencies; used by arc_accum, arc_bcd_cell and ascii_radix_converter.
package arc_pkg;

   localparam int CHAR_W = 8;
   localparam int DIG_W  = 4;

   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_0   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_1   = 8'h31;
   localparam logic [CHAR_W-1:0] CH_9   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UF  = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LA  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h66;
   localparam logic [CHAR_W-1:0] CH_B   = 8'h62;
   localparam logic [CHAR_W-1:0] CH_X   = 8'h78;

   typedef enum logic [1:0] {
      MODE_DEC,
      MODE_BIN,
      MODE_HEX
   } radix_mode_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_BAD_DIGIT,
      STAT_OVERFLOW
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_EMIT,
      ST_ERROR
   } fsm_state_type;

   typedef enum logic [1:0] {
      KIND_DEC,
      KIND_BIN,
      KIND_HEX
   } dig_kind_type;

   typedef struct packed {
      logic             ok;
      logic [DIG_W-1:0] val;
   } digit_type;

   // outcome of one character step, seen by the sequencer
   typedef struct packed {
      radix_mode_type mode;
      status_type     status;
   } acc_res_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift_dig;
   } cell_ctl_type;

   function automatic digit_type digit_decode(input logic [CHAR_W-1:0] c,
                                              input radix_mode_type    mode);
      digit_type r;
      r.ok  = 1'b0;
      r.val = '0;
      if (mode == MODE_BIN) begin
         if (c == CH_0 || c == CH_1) begin
            r.ok  = 1'b1;
            r.val = DIG_W'(c - CH_0);
         end
      end else if (c inside {[CH_0:CH_9]}) begin
         r.ok  = 1'b1;
         r.val = DIG_W'(c - CH_0);
      end else if (mode == MODE_HEX && c inside {[CH_UA:CH_UF]}) begin
         r.ok  = 1'b1;
         r.val = DIG_W'(c - CH_UA + 8'd10);
      end else if (mode == MODE_HEX && c inside {[CH_LA:CH_LF]}) begin
         r.ok  = 1'b1;
         r.val = DIG_W'(c - CH_LA + 8'd10);
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIG_W-1:0] d);
      logic [CHAR_W-1:0] r;
      if (d < 4'd10) begin
         r = CH_0 + {4'b0, d};
      end else begin
         r = CH_UA + {4'b0, d} - 8'd10;
      end
      return r;
   endfunction

endpackage

FILE: rtl/arc_accum.sv
// Character parser and value accumulator: base detection, prefix skip, digit and overflow checks.
// Depends on arc_pkg.
module arc_accum #(
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [arc_pkg::CHAR_W-1:0]    in_char,
   input  logic                          in_last,
   output logic [VALUE_BITS-1:0]         value,
   output arc_pkg::acc_res_type          res
);

   localparam int WW = VALUE_BITS + 4;

   logic [VALUE_BITS-1:0]           acc_ff, acc_in;
   arc_pkg::radix_mode_type         mode_ff, mode_in;
   arc_pkg::status_type             err_ff, err_in;
   logic [1:0]                      idx_ff, idx_in;
   logic [arc_pkg::DIG_W-1:0]       held_val_ff, held_val_in;
   logic                            held_bad_ff, held_bad_in;

   logic                            is_first, is_second, prefix, take_dig;
   arc_pkg::radix_mode_type         dmode;
   arc_pkg::digit_type              dig, first_dig;
   logic [WW-1:0]                   prev, prod, next;

   assign is_first  = (idx_ff == 2'd0);
   assign is_second = (idx_ff == 2'd1);
   assign prefix    = is_second && (in_char == arc_pkg::CH_X || in_char == arc_pkg::CH_B);
   assign take_dig  = (is_first && in_last) || (is_second && !prefix) || (idx_ff == 2'd2);
   assign dmode     = (is_first || is_second) ? arc_pkg::MODE_DEC : mode_ff;
   assign dig       = arc_pkg::digit_decode(in_char, dmode);
   assign first_dig = arc_pkg::digit_decode(in_char, arc_pkg::MODE_DEC);

   // a decimal string's first digit is held apart until the base is known
   assign prev = is_second ? WW'(held_val_ff) : WW'(acc_ff);

   always_comb begin
      case (dmode)
         arc_pkg::MODE_BIN: prod = prev << 1;
         arc_pkg::MODE_HEX: prod = prev << 4;
         default:           prod = (prev << 3) + (prev << 1);
      endcase
   end

   assign next = prod + WW'(dig.val);

   always_comb begin
      acc_in      = acc_ff;
      err_in      = err_ff;
      mode_in     = mode_ff;
      held_val_in = held_val_ff;
      held_bad_in = held_bad_ff;
      idx_in      = (idx_ff == 2'd2) ? idx_ff : idx_ff + 2'd1;
      if (is_first) begin
         held_val_in = first_dig.val;
         held_bad_in = !first_dig.ok;
      end
      if (is_second) begin
         if (in_char == arc_pkg::CH_X) begin
            mode_in = arc_pkg::MODE_HEX;
         end else if (in_char == arc_pkg::CH_B) begin
            mode_in = arc_pkg::MODE_BIN;
         end else begin
            mode_in = arc_pkg::MODE_DEC;
         end
      end
      if (take_dig && err_ff == arc_pkg::STAT_OK) begin
         if (is_second && held_bad_ff) begin
            err_in = arc_pkg::STAT_BAD_DIGIT;
         end else if (!dig.ok) begin
            err_in = arc_pkg::STAT_BAD_DIGIT;
         end else if (|next[WW-1:VALUE_BITS]) begin
            err_in = arc_pkg::STAT_OVERFLOW;
         end else begin
            acc_in = next[VALUE_BITS-1:0];
         end
      end
   end

   assign value      = acc_in;
   assign res.mode   = mode_in;
   assign res.status = err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         mode_ff     <= arc_pkg::MODE_DEC;
         err_ff      <= arc_pkg::STAT_OK;
         idx_ff      <= 2'd0;
         held_val_ff <= '0;
         held_bad_ff <= 1'b0;
      end else if (take) begin
         if (in_last) begin
            acc_ff      <= '0;
            mode_ff     <= arc_pkg::MODE_DEC;
            err_ff      <= arc_pkg::STAT_OK;
            idx_ff      <= 2'd0;
            held_val_ff <= '0;
            held_bad_ff <= 1'b0;
         end else begin
            acc_ff      <= acc_in;
            mode_ff     <= mode_in;
            err_ff      <= err_in;
            idx_ff      <= idx_in;
            held_val_ff <= held_val_in;
            held_bad_ff <= held_bad_in;
         end
      end
   end

endmodule

FILE: rtl/arc_bcd_cell.sv
// One decimal digit cell of the binary-to-BCD chain: add-3 and shift, or digit hand-off.
// Depends on arc_pkg.
module arc_bcd_cell (
   input  logic                       clock,
   input  arc_pkg::cell_ctl_type      ctl,
   input  logic                       bit_in,
   input  logic [arc_pkg::DIG_W-1:0]  dig_in,
   output logic                       bit_out,
   output logic [arc_pkg::DIG_W-1:0]  digit
);

   logic [arc_pkg::DIG_W-1:0] digit_ff, digit_in, adj;

   assign adj     = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign bit_out = adj[3];
   assign digit   = digit_ff;

   always_comb begin
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.dabble) begin
         digit_in = {adj[2:0], bit_in};
      end else if (ctl.shift_dig) begin
         digit_in = dig_in;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

FILE: rtl/ascii_radix_converter.sv
// ASCII radix converter: takes a number string one character per item on req_*,
// returns its digits in the other two bases on rsp_*, most significant digit first.
//   req_char/req_last: one character per item; req_last marks the final character.
//   A second character of 'x' or 'b' selects hex or binary, otherwise decimal.
//   rsp_section 0/1 tells the first and second conversion apart; rsp_last marks the
//   final item of a string. A bad digit or an overflow gives one item with
//   rsp_status set, rsp_char 0 and rsp_last 1.
// Throughput: characters before the last are taken at one per cycle. After the last
// character the block stops taking items until its final result is loaded:
//   decimal input: the binary digits, then the hex digits; binary or hex input:
//   the value is shifted through the BCD cell chain, then the decimal digits, then
//   the hex or binary digits for the second section.
// One digit position is visited per cycle, leading zeros included, so a stalled
// receiver only holds the sequencer on positions that produce a digit.
// The output register lets the last result wait while the next string starts.
// Reset (synchronous, active high) drops any pending result and clears the parser.
module ascii_radix_converter #(
   parameter int VALUE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [arc_pkg::CHAR_W-1:0] req_char,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [arc_pkg::CHAR_W-1:0] rsp_char,
   output logic                       rsp_section,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_last
);

   localparam int PW   = ((VALUE_BITS + 3) / 4) * 4;
   localparam int NHEX = PW / 4;
   localparam int NDIG = (VALUE_BITS * 302) / 1000 + 1;
   localparam int RW   = $clog2(PW + 1);

   arc_pkg::fsm_state_type      state_ff, state_in;
   logic [VALUE_BITS-1:0]       val_ff, val_in;
   arc_pkg::radix_mode_type     mode_ff, mode_in;
   arc_pkg::status_type         err_ff, err_in;
   logic [PW-1:0]               pw_ff, pw_in;
   logic [RW-1:0]               rem_ff, rem_in;
   logic                        started_ff, started_in;
   logic                        sec_ff, sec_in;
   arc_pkg::dig_kind_type       kind_ff, kind_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [arc_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                        rsp_section_ff, rsp_section_in;
   arc_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_load;

   logic                        in_take, last_take, out_free;
   logic                        rem_final, show, emit_step;
   logic [arc_pkg::DIG_W-1:0]   top_dig;
   logic [VALUE_BITS-1:0]       acc_value;
   arc_pkg::acc_res_type        acc_res;
   arc_pkg::cell_ctl_type       cell_ctl;

   logic [arc_pkg::DIG_W-1:0]   cell_dig   [NDIG-1:0];
   logic [arc_pkg::DIG_W-1:0]   dig_below  [NDIG-1:0];
   logic                        bit_below  [NDIG-1:0];
   logic                        cell_carry [NDIG-2:0];

   assign req_ready = (state_ff == arc_pkg::ST_IDLE);
   assign in_take   = req_valid && req_ready;
   assign last_take = in_take && req_last;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   arc_accum #(
      .VALUE_BITS (VALUE_BITS)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .take    (in_take),
      .in_char (req_char),
      .in_last (req_last),
      .value   (acc_value),
      .res     (acc_res)
   );

   // cell 0 is the least significant decimal digit; bits enter there MSB first
   for (genvar i = 0; i < NDIG; i++) begin : g_cell
      if (i == 0) begin : g_low
         assign bit_below[i] = pw_ff[PW-1];
         assign dig_below[i] = '0;
      end else begin : g_up
         assign bit_below[i] = cell_carry[i-1];
         assign dig_below[i] = cell_dig[i-1];
      end
      if (i == NDIG - 1) begin : g_top
         arc_bcd_cell u_cell (
            .clock   (clock),
            .ctl     (cell_ctl),
            .bit_in  (bit_below[i]),
            .dig_in  (dig_below[i]),
            .bit_out (),
            .digit   (cell_dig[i])
         );
      end else begin : g_mid
         arc_bcd_cell u_cell (
            .clock   (clock),
            .ctl     (cell_ctl),
            .bit_in  (bit_below[i]),
            .dig_in  (dig_below[i]),
            .bit_out (cell_carry[i]),
            .digit   (cell_dig[i])
         );
      end
   end

   always_comb begin
      case (kind_ff)
         arc_pkg::KIND_DEC: top_dig = cell_dig[NDIG-1];
         arc_pkg::KIND_BIN: top_dig = {3'b000, pw_ff[PW-1]};
         arc_pkg::KIND_HEX: top_dig = pw_ff[PW-1 -: 4];
         default:           top_dig = '0;
      endcase
   end

   assign rem_final = (rem_ff == RW'(1));
   // leading zeros are skipped, except the last position of a zero value
   assign show      = (top_dig != '0) || started_ff || rem_final;
   assign emit_step = (state_ff == arc_pkg::ST_EMIT) && (!show || out_free);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arc_pkg::ST_IDLE: begin
            if (last_take) begin
               if (acc_res.status != arc_pkg::STAT_OK) begin
                  state_in = arc_pkg::ST_ERROR;
               end else if (acc_res.mode == arc_pkg::MODE_DEC) begin
                  state_in = arc_pkg::ST_EMIT;
               end else begin
                  state_in = arc_pkg::ST_DABBLE;
               end
            end
         end
         arc_pkg::ST_DABBLE: begin
            if (rem_final) begin
               state_in = arc_pkg::ST_EMIT;
            end
         end
         arc_pkg::ST_EMIT: begin
            if (emit_step && rem_final && sec_ff) begin
               state_in = arc_pkg::ST_IDLE;
            end
         end
         arc_pkg::ST_ERROR: begin
            if (out_free) begin
               state_in = arc_pkg::ST_IDLE;
            end
         end
         default: state_in = arc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      val_in         = val_ff;
      mode_in        = mode_ff;
      err_in         = err_ff;
      pw_in          = pw_ff;
      rem_in         = rem_ff;
      started_in     = started_ff;
      sec_in         = sec_ff;
      kind_in        = kind_ff;
      cell_ctl       = '0;
      rsp_load       = 1'b0;
      rsp_char_in    = rsp_char_ff;
      rsp_section_in = rsp_section_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         arc_pkg::ST_IDLE: begin
            if (last_take) begin
               val_in         = acc_value;
               mode_in        = acc_res.mode;
               err_in         = acc_res.status;
               pw_in          = PW'(acc_value);
               rem_in         = RW'(PW);
               started_in     = 1'b0;
               sec_in         = 1'b0;
               cell_ctl.clear = 1'b1;
               kind_in        = (acc_res.mode == arc_pkg::MODE_DEC) ?
                                arc_pkg::KIND_BIN : arc_pkg::KIND_DEC;
            end
         end
         arc_pkg::ST_DABBLE: begin
            cell_ctl.dabble = 1'b1;
            pw_in           = pw_ff << 1;
            rem_in          = rem_ff - RW'(1);
            if (rem_final) begin
               rem_in     = RW'(NDIG);
               started_in = 1'b0;
            end
         end
         arc_pkg::ST_EMIT: begin
            if (emit_step) begin
               case (kind_ff)
                  arc_pkg::KIND_DEC: cell_ctl.shift_dig = 1'b1;
                  arc_pkg::KIND_BIN: pw_in = pw_ff << 1;
                  arc_pkg::KIND_HEX: pw_in = pw_ff << 4;
                  default:           pw_in = pw_ff;
               endcase
               rem_in = rem_ff - RW'(1);
               if (show) begin
                  started_in     = 1'b1;
                  rsp_load       = 1'b1;
                  rsp_char_in    = arc_pkg::digit_ascii(top_dig);
                  rsp_section_in = sec_ff;
                  rsp_status_in  = arc_pkg::STAT_OK;
                  rsp_last_in    = sec_ff && rem_final;
               end
               if (rem_final && !sec_ff) begin
                  sec_in     = 1'b1;
                  started_in = 1'b0;
                  pw_in      = PW'(val_ff);
                  if (mode_ff == arc_pkg::MODE_HEX) begin
                     kind_in = arc_pkg::KIND_BIN;
                     rem_in  = RW'(PW);
                  end else begin
                     kind_in = arc_pkg::KIND_HEX;
                     rem_in  = RW'(NHEX);
                  end
               end
            end
         end
         arc_pkg::ST_ERROR: begin
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_char_in    = arc_pkg::CH_NUL;
               rsp_section_in = 1'b0;
               rsp_status_in  = err_ff;
               rsp_last_in    = 1'b1;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff         <= val_in;
      mode_ff        <= mode_in;
      err_ff         <= err_in;
      pw_ff          <= pw_in;
      rem_ff         <= rem_in;
      started_ff     <= started_in;
      sec_ff         <= sec_in;
      kind_ff        <= kind_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_section_ff <= rsp_section_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_char    = rsp_char_ff;
   assign rsp_section = rsp_section_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
